// ===== rtl/pcps_pkg.sv =====
// Package for the plain-changes permutation stepper.
// Holds the field widths, the sequencer state type and the level decision record.
// No dependencies.
package pcps_pkg;

   localparam int MAX_ELEMENTS_DEF = 16;
   localparam int SIZE_W = 5;
   localparam int ELEM_W = 4;
   localparam int POS_W = 4;
   localparam int PERM_W = 64;
   localparam int ARITH_W = 6;
   localparam int SIZE_RESET = 4;
   localparam int SIZE_MIN = 2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } pcps_state_type;

   typedef struct packed {
      logic              swap;
      logic              fail;
      logic              flip;
      logic              bump;
      logic [ELEM_W-1:0] next_count;
      logic [POS_W-1:0]  pos;
   } pcps_step_type;

endpackage

// ===== rtl/pcps_if.sv =====
// Channel interfaces of the plain-changes permutation stepper.
// Depends on pcps_pkg for the payload widths.
interface pcps_req_if import pcps_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface pcps_rsp_if import pcps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PERM_W-1:0] perm_packed;
   logic [POS_W-1:0]  swap_position;
   logic              is_first;
   logic              done_res;
   modport source (output valid, output perm_packed, output swap_position,
                   output is_first, output done_res, input ready);
   modport sink (input valid, input perm_packed, input swap_position,
                 input is_first, input done_res, output ready);
endinterface

interface pcps_csr_if import pcps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] size_in_use;
   modport source (output valid, output size_in_use, input ready);
   modport sink (input valid, input size_in_use, output ready);
endinterface

// ===== rtl/pcps_level_unit.sv =====
// Shared level step unit: decides swap, carry or exhaustion for one level.
// Depends on pcps_pkg for widths and the decision record.
module pcps_level_unit import pcps_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   localparam int IDX_W = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1,
   localparam int NW = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic [IDX_W-1:0]  lvl,
   input  logic [ELEM_W-1:0] count,
   input  logic              dir,
   input  logic [IDX_W-1:0]  shift,
   input  logic [NW-1:0]     n,
   output pcps_step_type     dec
);

   logic                      up;
   logic                      at_top;
   logic                      at_bottom;
   logic                      move;
   logic                      oob;
   logic signed [ARITH_W-1:0] a;
   logic signed [ARITH_W-1:0] b;
   logic signed [ARITH_W-1:0] n_s;

   always_comb begin
      up = ~dir;
      at_top = up && (count == ELEM_W'(lvl));
      at_bottom = dir && (count == '0);
      move = at_top || at_bottom;
      a = $signed(ARITH_W'(lvl)) - $signed(ARITH_W'(count)) + $signed(ARITH_W'(shift));
      b = up ? a - ARITH_W'(1) : a + ARITH_W'(1);
      n_s = $signed(ARITH_W'(n));
      oob = (a < 0) || (b < 0) || (a >= n_s) || (b >= n_s);
      dec.swap = !move && !oob;
      dec.fail = (!move && oob) || (move && (lvl == '0));
      dec.flip = move && !(at_top && (lvl == '0));
      dec.bump = at_top;
      dec.next_count = up ? count + ELEM_W'(1) : count - ELEM_W'(1);
      dec.pos = up ? POS_W'(b) : POS_W'(a);
   end

endmodule

// ===== rtl/pcps_level_store.sv =====
// Per-level offset counters and direction bits of the plain-changes scheme.
// Depends on pcps_pkg for the counter width.
module pcps_level_store import pcps_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   localparam int IDX_W = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic [IDX_W-1:0]  lvl,
   input  logic              count_we,
   input  logic [ELEM_W-1:0] count_wr,
   input  logic              flip,
   output logic [ELEM_W-1:0] count_rd,
   output logic              dir_rd
);

   logic [ELEM_W-1:0] count_ff [MAX_ELEMENTS];
   logic [ELEM_W-1:0] count_in [MAX_ELEMENTS];
   logic              dir_ff [MAX_ELEMENTS];
   logic              dir_in [MAX_ELEMENTS];

   assign count_rd = count_ff[lvl];
   assign dir_rd = dir_ff[lvl];

   always_comb begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         count_in[i] = count_ff[i];
         dir_in[i] = dir_ff[i];
         if (clear) begin
            count_in[i] = '0;
            dir_in[i] = 1'b0;
         end else if (lvl == IDX_W'(i)) begin
            if (count_we) begin
               count_in[i] = count_wr;
            end
            if (flip) begin
               dir_in[i] = ~dir_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         if (reset) begin
            count_ff[i] <= '0;
            dir_ff[i] <= 1'b0;
         end else begin
            count_ff[i] <= count_in[i];
            dir_ff[i] <= dir_in[i];
         end
      end
   end

endmodule

// ===== rtl/pcps_perm_bank.sv =====
// Permutation register bank with identity load, adjacent swap and packing.
// Depends on pcps_pkg for element and packed widths.
module pcps_perm_bank import pcps_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   localparam int NW = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              swap_en,
   input  logic [POS_W-1:0]  swap_pos,
   input  logic [NW-1:0]     n,
   output logic [PERM_W-1:0] packed_next
);

   logic [ELEM_W-1:0] perm_ff [MAX_ELEMENTS];
   logic [ELEM_W-1:0] perm_in [MAX_ELEMENTS];

   for (genvar gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_lane
      localparam int Lo = (gi > 0) ? gi - 1 : 0;
      localparam int Hi = (gi < MAX_ELEMENTS - 1) ? gi + 1 : gi;

      always_comb begin
         perm_in[gi] = perm_ff[gi];
         if (load) begin
            perm_in[gi] = ELEM_W'(gi);
         end else if (swap_en && (swap_pos == POS_W'(gi))) begin
            perm_in[gi] = perm_ff[Hi];
         end else if (swap_en && (gi > 0) && (swap_pos == POS_W'(Lo))) begin
            perm_in[gi] = perm_ff[Lo];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            perm_ff[gi] <= ELEM_W'(gi);
         end else begin
            perm_ff[gi] <= perm_in[gi];
         end
      end

      assign packed_next[gi*ELEM_W +: ELEM_W] = (NW'(gi) < n) ? perm_in[gi] : '0;
   end

   if (MAX_ELEMENTS * ELEM_W < PERM_W) begin : g_pad
      assign packed_next[PERM_W-1:MAX_ELEMENTS*ELEM_W] = '0;
   end

endmodule

// ===== rtl/plain_changes_permutation_step.sv =====
// Top level of the plain-changes permutation stepper: sequencer, size register
// and result register. Depends on pcps_pkg, pcps_if and the pcps_* submodules.
//
//   channel  | role   | handshake    | payload
//   req_if   | in     | valid/ready  | restart
//   rsp_if   | out    | valid/ready  | perm_packed, swap_position, is_first, done_res
//   csr_if   | in     | valid/ready  | size_in_use
//
// A restart request, or an advance after the last permutation, is answered directly from idle.
// An advance is accepted in idle, then the shared level unit visits the levels from the top
// down: usually one, at most n when the carry walks down to the lowest level.
// The request side is ready only while the sequencer idles and the result register is
// free or being drained. Reset is synchronous and restores the identity with n = 4.
module plain_changes_permutation_step import pcps_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   localparam int IDX_W = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1,
   localparam int NW = $clog2(MAX_ELEMENTS + 1)
) (
   input logic        clock,
   input logic        reset,
   pcps_req_if.sink   req_if,
   pcps_rsp_if.source rsp_if,
   pcps_csr_if.sink   csr_if
);

   localparam int NReset = (SIZE_RESET < MAX_ELEMENTS) ? SIZE_RESET : MAX_ELEMENTS;

   pcps_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  lvl_ff, lvl_in;
   logic [IDX_W-1:0]  shift_ff, shift_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [SIZE_W-1:0] size_ff;
   logic              finished_ff, finished_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PERM_W-1:0] rsp_perm_ff;
   logic [POS_W-1:0]  rsp_pos_ff, pos_out;
   logic              rsp_first_ff, first_out;
   logic              rsp_done_ff, done_out;

   logic              req_fire;
   logic              publish;
   logic              load;
   logic              swap_en;
   logic              count_we;
   logic              flip_en;
   logic              store_clear;
   logic [NW-1:0]     n_clamp;
   logic [ELEM_W-1:0] count_rd;
   logic              dir_rd;
   logic [PERM_W-1:0] packed_next;
   pcps_step_type     dec;

   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_fire = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.perm_packed = rsp_perm_ff;
   assign rsp_if.swap_position = rsp_pos_ff;
   assign rsp_if.is_first = rsp_first_ff;
   assign rsp_if.done_res = rsp_done_ff;

   always_comb begin
      if (size_ff < SIZE_W'(SIZE_MIN)) begin
         n_clamp = NW'(SIZE_MIN);
      end else if (size_ff > SIZE_W'(MAX_ELEMENTS)) begin
         n_clamp = NW'(MAX_ELEMENTS);
      end else begin
         n_clamp = NW'(size_ff);
      end
   end

   pcps_level_unit #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_level_unit (
      .lvl   (lvl_ff),
      .count (count_rd),
      .dir   (dir_rd),
      .shift (shift_ff),
      .n     (n_ff),
      .dec   (dec)
   );

   pcps_level_store #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_level_store (
      .clock    (clock),
      .reset    (reset),
      .clear    (store_clear),
      .lvl      (lvl_ff),
      .count_we (count_we),
      .count_wr (dec.next_count),
      .flip     (flip_en),
      .count_rd (count_rd),
      .dir_rd   (dir_rd)
   );

   pcps_perm_bank #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_perm_bank (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .swap_en     (swap_en),
      .swap_pos    (dec.pos),
      .n           (n_in),
      .packed_next (packed_next)
   );

   always_comb begin
      state_in = state_ff;
      lvl_in = lvl_ff;
      shift_in = shift_ff;
      n_in = n_ff;
      finished_in = finished_ff;
      publish = 1'b0;
      pos_out = '0;
      first_out = 1'b0;
      done_out = 1'b0;
      load = 1'b0;
      swap_en = 1'b0;
      count_we = 1'b0;
      flip_en = 1'b0;
      store_clear = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.restart) begin
                  n_in = n_clamp;
                  load = 1'b1;
                  store_clear = 1'b1;
                  finished_in = 1'b0;
                  publish = 1'b1;
                  first_out = 1'b1;
               end else if (finished_ff) begin
                  publish = 1'b1;
                  done_out = 1'b1;
               end else begin
                  state_in = ST_WALK;
                  lvl_in = IDX_W'(n_ff - NW'(1));
                  shift_in = '0;
               end
            end
         end
         ST_WALK: begin
            if (dec.swap) begin
               swap_en = 1'b1;
               count_we = 1'b1;
               publish = 1'b1;
               pos_out = dec.pos;
               state_in = ST_IDLE;
            end else begin
               flip_en = dec.flip;
               if (dec.fail) begin
                  finished_in = 1'b1;
                  publish = 1'b1;
                  done_out = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  lvl_in = lvl_ff - IDX_W'(1);
                  if (dec.bump) begin
                     shift_in = shift_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = publish || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lvl_ff <= '0;
         shift_ff <= '0;
         n_ff <= NW'(NReset);
         size_ff <= SIZE_W'(SIZE_RESET);
         finished_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lvl_ff <= lvl_in;
         shift_ff <= shift_in;
         n_ff <= n_in;
         finished_ff <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            size_ff <= csr_if.size_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (publish) begin
         rsp_perm_ff <= packed_next;
         rsp_pos_ff <= pos_out;
         rsp_first_ff <= first_out;
         rsp_done_ff <= done_out;
      end
   end

   // The walk never runs once the sequence is exhausted.
   a_walk_not_finished: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !finished_ff)
      else $error("level walk running after the sequence was exhausted");

   // The result register is free for the whole walk.
   a_walk_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !rsp_valid_ff)
      else $error("result register occupied during a level walk");

   // A restart result carries no swap and no done flag.
   a_first_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_first_ff) |-> ((rsp_pos_ff == '0) && !rsp_done_ff))
      else $error("restart result with swap or done set");

   // A done result is only produced with the exhausted flag set.
   a_done_sets_finished: assert property (@(posedge clock) disable iff (reset)
      (publish && done_out) |=> finished_ff)
      else $error("done result without the exhausted flag");

endmodule

// ===== sim/tb_plain_changes_permutation_step.sv =====
// Testbench for plain_changes_permutation_step: directed table, then random restart/advance runs.
// Each response is checked against a table entry or the in-bench plain-changes predictor, under varied backpressure.
// Depends on pcps_pkg, the pcps_* channel interfaces and the block's RTL.
`timescale 1ns / 100ps

module tb_plain_changes_permutation_step;
   import pcps_pkg::*;

   localparam int DIR_ROWS = 25;
   localparam int SETTLE_CYCLES = MAX_ELEMENTS_DEF + 8;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int ITEMS_PER_PHASE = 570;
   localparam logic [PERM_W-1:0] IDENT16 = 64'hFEDCBA9876543210;

   typedef struct packed {
      logic [PERM_W-1:0] perm;
      logic [POS_W-1:0]  pos;
      logic              is_first;
      logic              done_res;
   } perm_result_t;

   typedef struct packed {
      logic              wr_size;
      logic [SIZE_W-1:0] size;
      logic              restart;
      logic              typed;
      perm_result_t      res;
   } dir_row_t;

   localparam perm_result_t NO_RES = '0;

   logic clock = 1'b0;
   logic reset;

   pcps_req_if req_ch ();
   pcps_rsp_if rsp_ch ();
   pcps_csr_if csr_ch ();

   plain_changes_permutation_step u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #10 clock = ~clock;

   logic [ELEM_W-1:0] perm_q [MAX_ELEMENTS_DEF];
   logic [ELEM_W-1:0] cnt_q [MAX_ELEMENTS_DEF];
   logic              dir_q [MAX_ELEMENTS_DEF];
   logic              seq_done;
   int                n_act;
   logic [SIZE_W-1:0] size_q;

   perm_result_t pending_perms [$];
   dir_row_t     directed_rows [DIR_ROWS];
   int           fail_count = 0;
   int           items_sent = 0;
   int           req_idle = 0;
   int           rsp_idle = 0;
   int           hold_cycles = 0;

   function automatic void load_identity();
      for (int i = 0; i < MAX_ELEMENTS_DEF; i++) begin
         perm_q[i] = ELEM_W'(i);
         cnt_q[i] = '0;
         dir_q[i] = 1'b0;
      end
      seq_done = 1'b0;
   endfunction

   function automatic perm_result_t next_permutation(input logic restart_bit);
      perm_result_t r;
      int lvl, shift, c, q, a, b;
      logic [ELEM_W-1:0] t;
      logic moved, stop;
      r = '0;
      if (restart_bit) begin
         n_act = (size_q < SIZE_MIN) ? SIZE_MIN :
                 (size_q > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : int'(size_q);
         load_identity();
         r.is_first = 1'b1;
      end else if (seq_done) begin
         r.done_res = 1'b1;
      end else begin
         lvl = n_act - 1;
         shift = 0;
         moved = 1'b0;
         stop = 1'b0;
         while (lvl >= 0 && !moved && !stop) begin
            c = int'(cnt_q[lvl]);
            q = dir_q[lvl] ? c - 1 : c + 1;
            if (q >= 0 && q != lvl + 1) begin
               a = lvl - c + shift;
               b = lvl - q + shift;
               if (a < 0 || b < 0 || a >= n_act || b >= n_act) begin
                  stop = 1'b1;
               end else begin
                  t = perm_q[a];
                  perm_q[a] = perm_q[b];
                  perm_q[b] = t;
                  cnt_q[lvl] = ELEM_W'(q);
                  r.pos = POS_W'((a < b) ? a : b);
                  moved = 1'b1;
               end
            end else begin
               if (q >= 0) begin
                  if (lvl == 0) stop = 1'b1;
                  else shift++;
               end
               if (!stop) begin
                  dir_q[lvl] = !dir_q[lvl];
                  lvl--;
               end
            end
         end
         if (!moved) begin
            seq_done = 1'b1;
            r.done_res = 1'b1;
            r.pos = '0;
         end
      end
      for (int i = 0; i < n_act; i++) r.perm[ELEM_W*i +: ELEM_W] = perm_q[i];
      return r;
   endfunction

   task automatic send_req(input logic restart_bit, input logic typed,
                           input perm_result_t typed_res);
      perm_result_t want;
      while ($urandom_range(0, 99) < req_idle) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.restart <= restart_bit;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      want = next_permutation(restart_bit);
      if (typed) want = typed_res;
      pending_perms.push_back(want);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      req_ch.valid <= 1'b0;
      while (pending_perms.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.size_in_use <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      size_q = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle);
         end
      end
   end

   always @(posedge clock) begin : check_results
      perm_result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_perms.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected response: perm %h pos %0d first %b done %b",
                        rsp_ch.perm_packed, rsp_ch.swap_position, rsp_ch.is_first,
                        rsp_ch.done_res);
            fail_count++;
         end else begin
            want = pending_perms.pop_front();
            if (rsp_ch.perm_packed !== want.perm || rsp_ch.swap_position !== want.pos ||
                rsp_ch.is_first !== want.is_first || rsp_ch.done_res !== want.done_res) begin
               if (fail_count < 10)
                  $display("mismatch: expected perm %h pos %0d first %b done %b, %s",
                           want.perm, want.pos, want.is_first, want.done_res,
                           $sformatf("got perm %h pos %0d first %b done %b",
                                     rsp_ch.perm_packed, rsp_ch.swap_position,
                                     rsp_ch.is_first, rsp_ch.done_res));
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int len;
      int stop_at;
      logic [SIZE_W-1:0] sz;
      int fact [6];
      fact = '{1, 1, 2, 6, 24, 120};
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.restart = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.size_in_use = SIZE_W'(SIZE_RESET);
      size_q = SIZE_W'(SIZE_RESET);
      n_act = SIZE_RESET;
      load_identity();

      directed_rows = '{
         '{1'b0, 5'd0,  1'b0, 1'b1, '{64'h2310, 4'd2, 1'b0, 1'b0}},
         '{1'b0, 5'd0,  1'b0, 1'b0, NO_RES},
         '{1'b1, 5'd0,  1'b1, 1'b1, '{64'h10, 4'd0, 1'b1, 1'b0}},
         '{1'b0, 5'd0,  1'b0, 1'b1, '{64'h01, 4'd0, 1'b0, 1'b0}},
         '{1'b0, 5'd0,  1'b0, 1'b1, '{64'h01, 4'd0, 1'b0, 1'b1}},
         '{1'b0, 5'd0,  1'b0, 1'b1, '{64'h01, 4'd0, 1'b0, 1'b1}},
         '{1'b1, 5'd1,  1'b1, 1'b1, '{64'h10, 4'd0, 1'b1, 1'b0}},
         '{1'b1, 5'd3,  1'b0, 1'b1, '{64'h01, 4'd0, 1'b0, 1'b0}},
         '{1'b0, 5'd0,  1'b0, 1'b1, '{64'h01, 4'd0, 1'b0, 1'b1}},
         '{1'b0, 5'd0,  1'b1, 1'b1, '{64'h210, 4'd0, 1'b1, 1'b0}},
         '{1'b0, 5'd0,  1'b0, 1'b0, NO_RES},
         '{1'b0, 5'd0,  1'b0, 1'b0, NO_RES},
         '{1'b0, 5'd0,  1'b0, 1'b0, NO_RES},
         '{1'b0, 5'd0,  1'b0, 1'b0, NO_RES},
         '{1'b0, 5'd0,  1'b0, 1'b0, NO_RES},
         '{1'b0, 5'd0,  1'b0, 1'b0, NO_RES},
         '{1'b1, 5'd31, 1'b1, 1'b1, '{IDENT16, 4'd0, 1'b1, 1'b0}},
         '{1'b0, 5'd0,  1'b0, 1'b1, '{64'hEFDCBA9876543210, 4'd14, 1'b0, 1'b0}},
         '{1'b1, 5'd17, 1'b1, 1'b1, '{IDENT16, 4'd0, 1'b1, 1'b0}},
         '{1'b1, 5'd16, 1'b1, 1'b1, '{IDENT16, 4'd0, 1'b1, 1'b0}},
         '{1'b0, 5'd0,  1'b0, 1'b0, NO_RES},
         '{1'b0, 5'd0,  1'b0, 1'b0, NO_RES},
         '{1'b1, 5'd4,  1'b1, 1'b1, '{64'h3210, 4'd0, 1'b1, 1'b0}},
         '{1'b0, 5'd0,  1'b0, 1'b0, NO_RES},
         '{1'b0, 5'd0,  1'b1, 1'b1, '{64'h3210, 4'd0, 1'b1, 1'b0}}
      };

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      req_idle = 37;
      rsp_idle = 50;
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (directed_rows[i].wr_size) begin
            wait_all_results();
            write_size(directed_rows[i].size);
         end
         send_req(directed_rows[i].restart, directed_rows[i].typed, directed_rows[i].res);
      end

      for (int phase = 0; phase < 3; phase++) begin
         req_idle = (phase == 0) ? 37 : (phase == 1) ? 50 : 0;
         rsp_idle = (phase == 0) ? 50 : (phase == 1) ? 37 : 0;
         // The receiver stalls for a long stretch while requests keep coming.
         if (phase < 2) hold_cycles = HOLD_OFF_CYCLES;
         stop_at = items_sent + ITEMS_PER_PHASE;
         while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
               if ($urandom_range(0, 4) == 0) sz = SIZE_W'($urandom_range(0, 31));
               else sz = SIZE_W'($urandom_range(2, 7));
               wait_all_results();
               write_size(sz);
               send_req(1'b1, 1'b0, NO_RES);
               if (n_act <= 5 && $urandom_range(0, 2) != 0)
                  len = fact[n_act] - 1 + $urandom_range(0, 3);
               else
                  len = $urandom_range(1, (n_act <= 5) ? fact[n_act] : 200);
               for (int k = 0; k < len; k++)
                  send_req($urandom_range(0, 59) == 0, 1'b0, NO_RES);
            end else begin
               if ($urandom_range(0, 1) == 1) begin
                  wait_all_results();
                  write_size(SIZE_W'($urandom_range(0, 31)));
               end
               repeat ($urandom_range(1, 8)) send_req(1'($urandom_range(0, 1)), 1'b0, NO_RES);
            end
         end
      end

      wait_all_results();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/pcps_pkg.sv
rtl/pcps_if.sv
rtl/pcps_level_unit.sv
rtl/pcps_level_store.sv
rtl/pcps_perm_bank.sv
rtl/plain_changes_permutation_step.sv
sim/tb_plain_changes_permutation_step.sv
